### hdl/cwi_pkg.sv
`default_nettype none
package cwi_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int PRICE_WIDTH  = 32;
  localparam int VOLUME_WIDTH = 40;
  localparam int PERIOD_WIDTH = 7;
  localparam int RSI_WIDTH    = 23;
  localparam int CFG_IDX_W    = 2;

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int K_W    = $clog2(MAX_WINDOW + 1);
  localparam int SEEN_W = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W  = PRICE_WIDTH + PTR_W;
  localparam int VSUM_W = VOLUME_WIDTH + 1 + PTR_W;
  localparam int DVD_W  = SUM_W + RSI_WIDTH;
  localparam int DVS_W  = SUM_W + 1;
  localparam int DCNT_W = $clog2(DVD_W);

  localparam logic [RSI_WIDTH-1:0] RSI_FULL = RSI_WIDTH'(6553600);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_WINDOW + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RSI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBV = 2'd3;

  localparam logic [PERIOD_WIDTH-1:0] SMA_RESET = 7'd20;
  localparam logic [PERIOD_WIDTH-1:0] RSI_RESET = 7'd14;
  localparam logic [PERIOD_WIDTH-1:0] ATR_RESET = 7'd14;
  localparam logic [PERIOD_WIDTH-1:0] OBV_RESET = 7'd5;

  typedef struct packed {
    logic [PRICE_WIDTH-1:0]         close;
    logic signed [PRICE_WIDTH:0]    change;
    logic [PRICE_WIDTH-1:0]         range;
    logic signed [VOLUME_WIDTH:0]   svol;
  } ring_entry_t;

  function automatic logic [PERIOD_WIDTH-1:0] clamp_period(input logic [PERIOD_WIDTH-1:0] p);
    logic [PERIOD_WIDTH-1:0] r;
    r = p;
    if (p == '0) r = PERIOD_WIDTH'(1);
    else if (32'(p) > MAX_WINDOW) r = PERIOD_WIDTH'(MAX_WINDOW);
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/candle_window_indicators.sv
// Candle window indicators.
// One candle (high, low, close, volume) enters per input transaction on the
// in_valid/in_ready channel; one result (SMA, RSI, ATR, OBV direction) leaves
// per transaction on the out_valid/out_ready channel.
// Window lengths are written on the cfg channel (index 0 to 3) while idle;
// the user must keep to this, as the block itself does not enforce it.
// Each candle is written to a 64-entry ring RAM, then the sequencer reads the
// window back one entry per cycle and accumulates the sums. A shared
// bit-serial divider then forms SMA, RSI and ATR, one quotient bit per cycle;
// each division is a load, 61 quotient bits and a hand-over of the result.
// The next candle can be accepted at the earliest in the cycle after the
// result is loaded.
// The output register holds a result until out_ready; the block meanwhile
// accepts and processes the next candle, and waits before delivering it.
// Reset is synchronous: periods return to 20, 14, 14 and 5, history is
// emptied and all indicators read 0 until enough candles have been seen.
`default_nettype none
module candle_window_indicators import cwi_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [PRICE_WIDTH-1:0]   high_price,
  input  wire logic [PRICE_WIDTH-1:0]   low_price,
  input  wire logic [PRICE_WIDTH-1:0]   close_price,
  input  wire logic [VOLUME_WIDTH-1:0]  trade_volume,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [PRICE_WIDTH-1:0]        sma_value,
  output logic [RSI_WIDTH-1:0]          rsi_value,
  output logic [PRICE_WIDTH-1:0]        atr_value,
  output logic signed [1:0]             obv_trend,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [PERIOD_WIDTH-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_SMA  = 3'd2;
  localparam logic [2:0] S_RSI  = 3'd3;
  localparam logic [2:0] S_ATR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [PERIOD_WIDTH-1:0] sma_len, rsi_len, atr_len, obv_len;
  logic [PERIOD_WIDTH-1:0] ps, pr, pa, po;
  logic [PTR_W-1:0] wptr, raddr;
  logic [K_W-1:0] kcnt, rd_k;
  logic rd_valid;
  logic [SEEN_W-1:0] seen;
  logic [PRICE_WIDTH-1:0] prior_close;
  logic [SUM_W-1:0] close_sum, gain_sum, loss_sum, range_sum;
  logic signed [VSUM_W-1:0] vol_sum;
  logic div_start, div_done;
  logic [DVD_W-1:0] div_dividend, div_quotient;
  logic [DVS_W-1:0] div_divisor;
  logic [PRICE_WIDTH-1:0] sma_res, atr_res;
  logic [RSI_WIDTH-1:0] rsi_res;

  logic in_fire, issue;
  logic signed [PRICE_WIDTH:0] t1, d_h, d_l, neg_h, neg_l, change;
  logic [PRICE_WIDTH-1:0] a_h, a_l, m, tr;
  logic [VOLUME_WIDTH:0] vol_ext;
  ring_entry_t wentry, rentry;
  logic [PRICE_WIDTH:0] neg_change;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign issue     = (state == S_SUM) && (32'(kcnt) < MAX_WINDOW);

  always_comb begin
    t1    = $signed({1'b0, high_price}) - $signed({1'b0, low_price});
    d_h   = $signed({1'b0, high_price}) - $signed({1'b0, prior_close});
    d_l   = $signed({1'b0, low_price}) - $signed({1'b0, prior_close});
    neg_h = -d_h;
    neg_l = -d_l;
    a_h   = d_h[PRICE_WIDTH] ? neg_h[PRICE_WIDTH-1:0] : d_h[PRICE_WIDTH-1:0];
    a_l   = d_l[PRICE_WIDTH] ? neg_l[PRICE_WIDTH-1:0] : d_l[PRICE_WIDTH-1:0];
    m     = (a_h > a_l) ? a_h : a_l;
    tr    = (!t1[PRICE_WIDTH] && t1[PRICE_WIDTH-1:0] > m) ? t1[PRICE_WIDTH-1:0] : m;
    change = $signed({1'b0, close_price}) - $signed({1'b0, prior_close});
    vol_ext = {1'b0, trade_volume};
    wentry.close  = close_price;
    wentry.change = change;
    wentry.range  = tr;
    if (change[PRICE_WIDTH]) wentry.svol = $signed(-vol_ext);
    else if (change != '0) wentry.svol = $signed(vol_ext);
    else wentry.svol = '0;
  end

  cwi_ram #(.WIDTH($bits(ring_entry_t)), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (in_fire),
    .waddr (wptr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  assign neg_change = -rentry.change;

  always_comb begin
    div_dividend = DVD_W'(close_sum);
    div_divisor  = DVS_W'(ps);
    case (state)
      S_RSI: begin
        div_dividend = (DVD_W'(gain_sum) << 22) + (DVD_W'(gain_sum) << 21)
                     + (DVD_W'(gain_sum) << 18);
        div_divisor  = DVS_W'(gain_sum) + DVS_W'(loss_sum);
      end
      S_ATR: begin
        div_dividend = DVD_W'(range_sum);
        div_divisor  = DVS_W'(pa);
      end
      default: begin
        div_dividend = DVD_W'(close_sum);
        div_divisor  = DVS_W'(ps);
      end
    endcase
  end

  cwi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sma_len     <= SMA_RESET;
      rsi_len     <= RSI_RESET;
      atr_len     <= ATR_RESET;
      obv_len     <= OBV_RESET;
      wptr        <= '0;
      seen        <= '0;
      prior_close <= '0;
      kcnt        <= '0;
      rd_valid    <= 1'b0;
      div_start   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      div_start <= (state == S_SUM && !issue && !rd_valid)
                || (div_done && (state == S_SMA || state == S_RSI));
      rd_valid  <= issue;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SMA: sma_len <= cfg_data;
          CFG_RSI: rsi_len <= cfg_data;
          CFG_ATR: atr_len <= cfg_data;
          CFG_OBV: obv_len <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            wptr        <= (32'(wptr) == MAX_WINDOW - 1) ? '0 : wptr + PTR_W'(1);
            if (seen < SEEN_MAX) seen <= seen + SEEN_W'(1);
            prior_close <= close_price;
            kcnt        <= '0;
            state       <= S_SUM;
          end
        end
        S_SUM: begin
          if (issue) kcnt <= kcnt + K_W'(1);
          else if (!rd_valid) state <= S_SMA;
        end
        S_SMA: begin
          if (div_done) state <= S_RSI;
        end
        S_RSI: begin
          if (div_done) state <= S_ATR;
        end
        S_ATR: begin
          if (div_done) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ps        <= clamp_period(sma_len);
      pr        <= clamp_period(rsi_len);
      pa        <= clamp_period(atr_len);
      po        <= clamp_period(obv_len);
      raddr     <= wptr;
      close_sum <= '0;
      gain_sum  <= '0;
      loss_sum  <= '0;
      range_sum <= '0;
      vol_sum   <= '0;
    end
    if (issue) begin
      raddr <= (raddr == '0) ? PTR_W'(MAX_WINDOW - 1) : raddr - PTR_W'(1);
      rd_k  <= kcnt;
    end
    if (rd_valid) begin
      if (rd_k < K_W'(ps)) close_sum <= close_sum + SUM_W'(rentry.close);
      if (rd_k < K_W'(pr)) begin
        if (!rentry.change[PRICE_WIDTH] && rentry.change != '0)
          gain_sum <= gain_sum + SUM_W'(rentry.change[PRICE_WIDTH-1:0]);
        else
          loss_sum <= loss_sum + SUM_W'(neg_change[PRICE_WIDTH-1:0]);
      end
      if (rd_k < K_W'(pa)) range_sum <= range_sum + SUM_W'(rentry.range);
      if (32'(rd_k) + 1 < 32'(po)) begin
        vol_sum <= vol_sum + {{(VSUM_W-VOLUME_WIDTH-1){rentry.svol[VOLUME_WIDTH]}},
                              rentry.svol};
      end
    end
    if (div_done) begin
      case (state)
        S_SMA: sma_res <= (32'(seen) >= 32'(ps)) ? div_quotient[PRICE_WIDTH-1:0] : '0;
        S_RSI: begin
          if (32'(seen) <= 32'(pr)) rsi_res <= '0;
          else if (loss_sum == '0) rsi_res <= RSI_FULL;
          else rsi_res <= div_quotient[RSI_WIDTH-1:0];
        end
        S_ATR: atr_res <= (32'(seen) > 32'(pa)) ? div_quotient[PRICE_WIDTH-1:0] : '0;
        default: ;
      endcase
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      sma_value <= sma_res;
      rsi_value <= rsi_res;
      atr_value <= atr_res;
      if (32'(seen) <= 32'(po)) obv_trend <= 2'sd0;
      else if (vol_sum > 0) obv_trend <= 2'sd1;
      else if (vol_sum < 0) obv_trend <= -2'sd1;
      else obv_trend <= 2'sd0;
    end
  end

`ifndef SYNTH
  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rsi_value <= RSI_FULL)
    else $error("RSI result above full scale");
  a_accept_sums: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_SUM && kcnt == '0)
    else $error("accepted candle did not start the window pass");
  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    seen <= SEEN_MAX)
    else $error("candle count passed saturation");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == S_SMA || state == S_RSI || state == S_ATR))
    else $error("divider started outside a division step");
  a_obv_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> obv_trend != 2'b10)
    else $error("invalid OBV direction code");
`endif

endmodule
`default_nettype wire

### hdl/cwi_ram.sv
`default_nettype none
module cwi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/cwi_divider.sv
`default_nettype none
module cwi_divider import cwi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    rem_shift;
  logic              fits;

  assign rem_shift = {rem, quotient[DVD_W-1]};
  assign fits = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DCNT_W'(DVD_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(DVD_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DVD_W-2:0], fits};
      rem      <= fits ? DVS_W'(rem_shift - {1'b0, dvs}) : rem_shift[DVS_W-1:0];
    end
  end

endmodule
`default_nettype wire
